/* rtl/irasu_pkg.sv */
// shared types and constants for the i2c register access sequencer
package irasu_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;

    localparam int IN_DATA_W   = 56;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 24;
    localparam int OUT_USER_W  = 2;

    localparam logic [15:0] ADDR_HI_MASK = 16'hFF00;
    localparam logic [15:0] ADDR_LO_MASK = 16'h00FF;

    localparam logic [2:0] ST_START_SENT = 3'd0;
    localparam logic [2:0] ST_ADDR_ACKED = 3'd1;
    localparam logic [2:0] ST_BYTE_SENT  = 3'd2;
    localparam logic [2:0] ST_BYTE_RECV  = 3'd3;
    localparam logic [2:0] ST_STOP_IDLE  = 3'd4;

    typedef enum logic [1:0] {
        KIND_LOAD     = 2'd0,
        KIND_START    = 2'd1,
        KIND_EVENT    = 2'd2,
        KIND_READBACK = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_START = 2'd1,
        ACT_TX    = 2'd2,
        ACT_STOP  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_WAIT_START = 3'd1,
        PH_WAIT_ACK   = 3'd2,
        PH_WAIT_SENT  = 3'd3,
        PH_WAIT_RECV  = 3'd4,
        PH_WAIT_STOP  = 3'd5,
        PH_RESTART    = 3'd6
    } t_phase;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  entry_index;
        logic [7:0]        device_address;
        logic [15:0]       memory_address;
        logic [7:0]        write_byte;
        logic [CNT_W-1:0]  run_length;
        logic              read_run;
        logic [2:0]        bus_status;
        logic [7:0]        received_byte;
    } t_item;

    typedef struct packed {
        t_action     action;
        logic [7:0]  tx_byte;
        logic [7:0]  entry_data;
        logic        busy_res;
    } t_result;

endpackage

/* rtl/i2c_register_access_sequencer_unit.sv */
// top level: stream ports, input word register, result register
// an accepted input word is held in the input word register, and its result word in the result register
// throughput: one word per cycle while the output is not stalled, set by the per-word step of the sequencer state
// a result word waiting on the output holds the input word and stops the input side
// reset clears the sequencer state and the address width register
// entry tables are not reset and hold undefined values until loaded
module i2c_register_access_sequencer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // entry_index, device_address, memory_address, write_byte, run_length,
    // read_run, bus_status, received_byte, zero fill
    input  logic [irasu_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind
    input  logic [irasu_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tx_byte, entry_data, busy_res, zero fill
    output logic [irasu_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // action
    output logic [irasu_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

    logic                 r_in_vld;
    irasu_pkg::t_item     r_item;
    logic                 r_out_vld;
    irasu_pkg::t_result   r_out;
    irasu_pkg::t_result   w_res;
    logic                 w_adv;
    logic                 w_acc;

    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    irasu_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_adv),
        .i_item      (r_item),
        .o_result    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item.kind           <= irasu_pkg::t_kind'(s_axis_tuser[1:0]);
            r_item.entry_index    <= s_axis_tdata[3:0];
            r_item.device_address <= s_axis_tdata[11:4];
            r_item.memory_address <= s_axis_tdata[27:12];
            r_item.write_byte     <= s_axis_tdata[35:28];
            r_item.run_length     <= s_axis_tdata[40:36];
            r_item.read_run       <= s_axis_tdata[41];
            r_item.bus_status     <= s_axis_tdata[44:42];
            r_item.received_byte  <= s_axis_tdata[52:45];
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'b0, r_out.busy_res, r_out.entry_data, r_out.tx_byte};
    assign m_axis_tuser  = r_out.action;

endmodule

/* rtl/irasu_core.sv */
// sequencer state, entry tables and per-word step logic
module irasu_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_step,
    input  irasu_pkg::t_item  i_item,
    output irasu_pkg::t_result o_result
);

    logic                          r_two_byte;
    irasu_pkg::t_phase             r_phase, n_phase;
    logic                          r_busy, n_busy;
    logic                          r_read_mode, n_read_mode;
    logic                          r_addr_done, n_addr_done;
    logic                          r_data_done, n_data_done;
    logic [irasu_pkg::CNT_W-1:0]   r_cur, n_cur;
    logic [irasu_pkg::CNT_W-1:0]   r_len, n_len;

    logic [7:0]  r_dev_tbl  [irasu_pkg::ENTRIES];
    logic [15:0] r_addr_tbl [irasu_pkg::ENTRIES];
    logic [7:0]  r_data_tbl [irasu_pkg::ENTRIES];

    logic [irasu_pkg::IDX_W-1:0]   w_e;
    logic [irasu_pkg::IDX_W-1:0]   w_rd_idx;
    logic [7:0]                    w_dev;
    logic [15:0]                   w_addr;
    logic [7:0]                    w_data_rd;
    logic [irasu_pkg::CNT_W-1:0]   w_len_sat;
    logic                          w_start_ok;
    logic                          w_load;
    logic                          w_rx_wr;
    logic [irasu_pkg::ENTRIES-1:0] w_clr;
    logic [irasu_pkg::CNT_W-1:0]   w_cur_inc;
    logic                          w_ev;
    irasu_pkg::t_action            w_act;
    logic [7:0]                    w_tx;
    logic [7:0]                    w_rd;

    assign w_e = (r_cur < irasu_pkg::CNT_W'(irasu_pkg::ENTRIES))
               ? r_cur[irasu_pkg::IDX_W-1:0] : '0;
    assign w_rd_idx  = (i_item.kind == irasu_pkg::KIND_READBACK) ? i_item.entry_index : w_e;
    assign w_dev     = r_dev_tbl[w_e];
    assign w_addr    = r_addr_tbl[w_e];
    assign w_data_rd = r_data_tbl[w_rd_idx];
    assign w_cur_inc = r_cur + 1'b1;
    assign w_ev      = (i_item.kind == irasu_pkg::KIND_EVENT) && r_busy;

    assign w_len_sat = (i_item.run_length > irasu_pkg::CNT_W'(irasu_pkg::ENTRIES))
                     ? irasu_pkg::CNT_W'(irasu_pkg::ENTRIES) : i_item.run_length;
    assign w_start_ok = (i_item.kind == irasu_pkg::KIND_START) && !r_busy
                     && (i_item.run_length != '0);
    assign w_load     = i_step && (i_item.kind == irasu_pkg::KIND_LOAD) && !r_busy;
    assign w_rx_wr    = i_step && w_ev && (r_phase == irasu_pkg::PH_WAIT_RECV)
                     && (i_item.bus_status == irasu_pkg::ST_BYTE_RECV);

    always_comb begin
        for (int i = 0; i < irasu_pkg::ENTRIES; i++) begin
            w_clr[i] = i_step && w_start_ok && i_item.read_run
                    && (irasu_pkg::CNT_W'(i) < w_len_sat);
        end
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_busy      = r_busy;
        n_read_mode = r_read_mode;
        n_addr_done = r_addr_done;
        n_data_done = r_data_done;
        n_cur       = r_cur;
        n_len       = r_len;
        if (w_start_ok) begin
            n_read_mode = i_item.read_run;
            n_busy      = 1'b1;
            n_addr_done = 1'b0;
            n_data_done = 1'b0;
            n_cur       = '0;
            n_len       = w_len_sat;
            n_phase     = irasu_pkg::PH_WAIT_START;
        end else if (w_ev) begin
            unique case (r_phase)
                irasu_pkg::PH_WAIT_START: begin
                    if (i_item.bus_status == irasu_pkg::ST_START_SENT) begin
                        n_phase = (r_read_mode && r_addr_done)
                                ? irasu_pkg::PH_WAIT_RECV : irasu_pkg::PH_WAIT_ACK;
                    end
                end
                irasu_pkg::PH_WAIT_ACK: begin
                    if (i_item.bus_status == irasu_pkg::ST_ADDR_ACKED) begin
                        if (!r_two_byte) begin
                            n_addr_done = 1'b1;
                        end
                        n_phase = irasu_pkg::PH_WAIT_SENT;
                    end
                end
                irasu_pkg::PH_WAIT_SENT: begin
                    if (i_item.bus_status == irasu_pkg::ST_BYTE_SENT) begin
                        priority if (r_two_byte && !r_addr_done) begin
                            n_addr_done = 1'b1;
                        end else if (r_read_mode) begin
                            n_phase = irasu_pkg::PH_WAIT_START;
                        end else if (!r_data_done) begin
                            n_data_done = 1'b1;
                        end else begin
                            n_cur       = w_cur_inc;
                            n_addr_done = 1'b0;
                            n_data_done = 1'b0;
                            if (w_cur_inc < r_len) begin
                                n_phase = irasu_pkg::PH_WAIT_STOP;
                            end else begin
                                n_busy      = 1'b0;
                                n_read_mode = 1'b0;
                                n_phase     = irasu_pkg::PH_IDLE;
                            end
                        end
                    end
                end
                irasu_pkg::PH_WAIT_RECV: begin
                    if (i_item.bus_status == irasu_pkg::ST_BYTE_RECV) begin
                        n_cur       = w_cur_inc;
                        n_addr_done = 1'b0;
                        n_data_done = 1'b0;
                        if (w_cur_inc < r_len) begin
                            n_phase = irasu_pkg::PH_WAIT_STOP;
                        end else begin
                            n_busy      = 1'b0;
                            n_read_mode = 1'b0;
                            n_phase     = irasu_pkg::PH_IDLE;
                        end
                    end
                end
                irasu_pkg::PH_WAIT_STOP: begin
                    if (i_item.bus_status == irasu_pkg::ST_STOP_IDLE) begin
                        n_phase = irasu_pkg::PH_RESTART;
                    end
                end
                irasu_pkg::PH_RESTART: begin
                    if (i_item.bus_status == irasu_pkg::ST_STOP_IDLE) begin
                        n_phase = irasu_pkg::PH_WAIT_START;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        w_act = irasu_pkg::ACT_NONE;
        w_tx  = '0;
        w_rd  = '0;
        if (i_item.kind == irasu_pkg::KIND_READBACK) begin
            w_rd = w_data_rd;
        end
        if (w_start_ok) begin
            w_act = irasu_pkg::ACT_START;
        end else if (w_ev) begin
            unique case (r_phase)
                irasu_pkg::PH_WAIT_START: begin
                    if (i_item.bus_status == irasu_pkg::ST_START_SENT) begin
                        w_act = irasu_pkg::ACT_TX;
                        w_tx  = (r_read_mode && r_addr_done) ? {w_dev[7:1], 1'b1} : w_dev;
                    end
                end
                irasu_pkg::PH_WAIT_ACK: begin
                    if (i_item.bus_status == irasu_pkg::ST_ADDR_ACKED) begin
                        w_act = irasu_pkg::ACT_TX;
                        w_tx  = r_two_byte ? 8'((w_addr & irasu_pkg::ADDR_HI_MASK) >> 8)
                                           : 8'(w_addr & irasu_pkg::ADDR_LO_MASK);
                    end
                end
                irasu_pkg::PH_WAIT_SENT: begin
                    if (i_item.bus_status == irasu_pkg::ST_BYTE_SENT) begin
                        priority if (r_two_byte && !r_addr_done) begin
                            w_act = irasu_pkg::ACT_TX;
                            w_tx  = 8'(w_addr & irasu_pkg::ADDR_LO_MASK);
                        end else if (r_read_mode) begin
                            w_act = irasu_pkg::ACT_START;
                        end else if (!r_data_done) begin
                            w_act = irasu_pkg::ACT_TX;
                            w_tx  = w_data_rd;
                        end else begin
                            w_act = irasu_pkg::ACT_STOP;
                        end
                    end
                end
                irasu_pkg::PH_WAIT_RECV: begin
                    if (i_item.bus_status == irasu_pkg::ST_BYTE_RECV) begin
                        w_act = irasu_pkg::ACT_STOP;
                    end
                end
                irasu_pkg::PH_RESTART: begin
                    if (i_item.bus_status == irasu_pkg::ST_STOP_IDLE) begin
                        w_act = irasu_pkg::ACT_START;
                    end
                end
                default: begin
                    w_act = irasu_pkg::ACT_NONE;
                end
            endcase
        end
    end

    assign o_result.action     = w_act;
    assign o_result.tx_byte    = w_tx;
    assign o_result.entry_data = w_rd;
    assign o_result.busy_res   = n_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_byte  <= 1'b0;
            r_phase     <= irasu_pkg::PH_IDLE;
            r_busy      <= 1'b0;
            r_read_mode <= 1'b0;
            r_addr_done <= 1'b0;
            r_data_done <= 1'b0;
            r_cur       <= '0;
            r_len       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_two_byte <= i_cfg_wdata;
            end
            if (i_step) begin
                r_phase     <= n_phase;
                r_busy      <= n_busy;
                r_read_mode <= n_read_mode;
                r_addr_done <= n_addr_done;
                r_data_done <= n_data_done;
                r_cur       <= n_cur;
                r_len       <= n_len;
            end
        end
    end

    // entry tables, no reset
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_dev_tbl[i_item.entry_index]  <= i_item.device_address;
            r_addr_tbl[i_item.entry_index] <= i_item.memory_address;
        end
        for (int i = 0; i < irasu_pkg::ENTRIES; i++) begin
            if (w_clr[i]) begin
                r_data_tbl[i] <= '0;
            end else if (w_load && (i_item.entry_index == irasu_pkg::IDX_W'(i))) begin
                r_data_tbl[i] <= i_item.write_byte;
            end else if (w_rx_wr && (w_e == irasu_pkg::IDX_W'(i))) begin
                r_data_tbl[i] <= i_item.received_byte;
            end
        end
    end

    a_busy_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_phase != irasu_pkg::PH_IDLE))
        else $error("busy flag and phase disagree");

    a_cur_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cur < r_len))
        else $error("current entry past end of run while busy");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= irasu_pkg::CNT_W'(irasu_pkg::ENTRIES))
        else $error("run length above table size");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (o_result.action == irasu_pkg::ACT_START)) |=> r_busy)
        else $error("start issued without a run in progress");

    a_data_write_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_data_done |-> !r_read_mode)
        else $error("data byte sent during a read run");

endmodule
